// ===== rtl/lps_pkg.sv =====
// Shared types and constants for the bilinear line profile sampler.
package lps_pkg;

  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned PIX_BITS   = 16;
  localparam int unsigned ADDR_BITS  = 16;
  localparam int unsigned COORD_BITS = 18;
  localparam int unsigned POS_BITS   = 21;
  localparam int unsigned DIVD_BITS  = 28;
  localparam int unsigned DIVS_BITS  = 11;
  localparam int unsigned ACC_BITS   = 33;
  localparam int unsigned VAL_BITS   = 24;

  localparam logic [8:0] DIM_MAX = 9'd256;
  localparam logic [8:0] ONE_FX  = 9'd256;

  typedef enum logic [2:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_START_X = 3'd2,
    REG_START_Y = 3'd3,
    REG_END_X   = 3'd4,
    REG_END_Y   = 3'd5,
    REG_COUNT   = 3'd6
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_FIX, ST_CHK,
    ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4,
    ST_MAC0, ST_MAC1, ST_MAC2, ST_MAC3, ST_MAC4, ST_MAC5,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] addr;
    logic [PIX_BITS-1:0]  wdata;
  } store_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIVD_BITS-1:0] quo;
    logic                 rem_nz;
  } div_stat_t;

endpackage

// ===== rtl/lps_store.sv =====
// Single-port image memory, registered read data.
module lps_store (
  input  logic                          clk,
  input  lps_pkg::store_req_t           req,
  output logic [lps_pkg::PIX_BITS-1:0]  rdata
);

  logic [lps_pkg::PIX_BITS-1:0] mem [2**lps_pkg::ADDR_BITS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

// ===== rtl/lps_div.sv =====
// Restoring divider, one quotient bit per cycle.
module lps_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [lps_pkg::DIVD_BITS-1:0]  dividend,
  input  logic [lps_pkg::DIVS_BITS-1:0]  divisor,
  output lps_pkg::div_stat_t             stat
);

  logic [lps_pkg::DIVS_BITS-1:0] rem_r, rem_nxt;
  logic [lps_pkg::DIVS_BITS-1:0] dvs_r;
  logic [lps_pkg::DIVD_BITS-1:0] quo_r, quo_nxt;
  logic [4:0]                    cnt_r;
  logic                          busy_r, done_r;
  logic [lps_pkg::DIVS_BITS:0]   shifted;

  always_comb begin
    shifted = {rem_r, quo_r[lps_pkg::DIVD_BITS-1]};
    if (shifted >= {1'b0, dvs_r}) begin
      rem_nxt = lps_pkg::DIVS_BITS'(shifted - {1'b0, dvs_r});
      quo_nxt = {quo_r[lps_pkg::DIVD_BITS-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[lps_pkg::DIVS_BITS-1:0];
      quo_nxt = {quo_r[lps_pkg::DIVD_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(lps_pkg::DIVD_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.done   = done_r;
  assign stat.quo    = quo_r;
  assign stat.rem_nz = (rem_r != '0);

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without run");
`endif

endmodule

// ===== rtl/bilinear_line_profile_sampler.sv =====
// Top level: line profile sequencer with shared multiplier, divider and image store.
//
//  channel | direction | transfer when        | payload
//  in_     | in        | in_valid & !in_stall | kind, pixel_col/row/value, sample_index
//  out_    | out       | out_valid & !out_stall | sample_number/value/inside, last_sample
//  cfg_    | in        | cfg_we               | cfg_index, cfg_data
//
// A pixel write is accepted in IDLE and does not stall the input. A sample inside the image
// runs from its transfer through two axis passes (setup, 28 divider steps, done,
// fixup), one check, five store read states, six multiply steps on the 24x9 blend
// multiplier and the result load before the next item is accepted. An outside sample
// skips reads and blend. A sample at or beyond sample_count is dropped without a stall.
// Reset is synchronous; the image store is not cleared.
// in_stall is high while a sample is in flight or its result cannot be loaded.
module bilinear_line_profile_sampler (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         in_kind,
  input  logic [7:0]   in_pixel_col,
  input  logic [7:0]   in_pixel_row,
  input  logic [15:0]  in_pixel_value,
  input  logic [9:0]   in_sample_index,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [9:0]   out_sample_number,
  output logic [23:0]  out_sample_value,
  output logic         out_sample_inside,
  output logic         out_last_sample,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [17:0]  cfg_data
);

  // configuration
  logic [8:0]         width_r, height_r;
  logic signed [17:0] sx_r, sy_r, ex_r, ey_r;
  logic [10:0]        count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lps_pkg::DIM_MAX;
      height_r <= lps_pkg::DIM_MAX;
      sx_r <= '0; sy_r <= '0; ex_r <= '0; ey_r <= '0;
      count_r <= '0;
    end else if (cfg_we) begin
      unique case (lps_pkg::reg_idx_t'(cfg_index))
        lps_pkg::REG_WIDTH:   width_r  <= cfg_data[8:0];
        lps_pkg::REG_HEIGHT:  height_r <= cfg_data[8:0];
        lps_pkg::REG_START_X: sx_r     <= $signed(cfg_data);
        lps_pkg::REG_START_Y: sy_r     <= $signed(cfg_data);
        lps_pkg::REG_END_X:   ex_r     <= $signed(cfg_data);
        lps_pkg::REG_END_Y:   ey_r     <= $signed(cfg_data);
        lps_pkg::REG_COUNT:   count_r  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  lps_pkg::state_t state_r, state_nxt;

  logic                         in_xfer;
  logic                         out_free;
  logic [9:0]                   idx_r;
  logic                         axis_r;   // 0: x pass, 1: y pass
  logic                         neg_r;
  logic signed [lps_pkg::POS_BITS-1:0] posx_r, posy_r;
  logic                         inside_r;
  logic [15:0]                  pix_r [4];
  logic [lps_pkg::ACC_BITS-1:0] acc_r;
  logic [23:0]                  top_r, bot_r;
  logic                         out_valid_r, out_inside_r, out_last_r;
  logic [9:0]                   out_num_r;
  logic [23:0]                  out_val_r;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // product i*|d| for the current axis
  logic signed [18:0] d_s;
  logic [17:0]        d_mag;
  logic [lps_pkg::DIVD_BITS-1:0] ip_prod;

  always_comb begin
    d_s     = axis_r ? (19'(ey_r) - 19'(sy_r)) : (19'(ex_r) - 19'(sx_r));
    d_mag   = d_s[18] ? 18'(-d_s) : d_s[17:0];
    ip_prod = lps_pkg::DIVD_BITS'(idx_r) * lps_pkg::DIVD_BITS'(d_mag);
  end

  lps_pkg::div_stat_t div_stat;
  logic               div_start;

  lps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ip_prod),
    .divisor  (count_r),
    .stat     (div_stat)
  );

  // floor division result, then position minus half a pixel
  logic signed [lps_pkg::POS_BITS-1:0] q_s, pos_s;
  always_comb begin
    q_s = $signed({1'b0, div_stat.quo[lps_pkg::POS_BITS-2:0]});
    if (neg_r) begin
      q_s = -q_s - (div_stat.rem_nz ? lps_pkg::POS_BITS'(1) : lps_pkg::POS_BITS'(0));
    end
    pos_s = (axis_r ? lps_pkg::POS_BITS'(sy_r) : lps_pkg::POS_BITS'(sx_r)) + q_s
          - lps_pkg::POS_BITS'(1 << (lps_pkg::FRAC_BITS - 1));
  end

  // interpolable area check; a zero dimension gives a negative limit
  logic [8:0]                          w_sat, h_sat;
  logic signed [lps_pkg::POS_BITS-1:0] lim_x, lim_y;
  logic                                inside_c;
  always_comb begin
    w_sat = (width_r  > lps_pkg::DIM_MAX) ? lps_pkg::DIM_MAX : width_r;
    h_sat = (height_r > lps_pkg::DIM_MAX) ? lps_pkg::DIM_MAX : height_r;
    lim_x = (lps_pkg::POS_BITS'(w_sat) - lps_pkg::POS_BITS'(1)) <<< lps_pkg::FRAC_BITS;
    lim_y = (lps_pkg::POS_BITS'(h_sat) - lps_pkg::POS_BITS'(1)) <<< lps_pkg::FRAC_BITS;
    inside_c = !posx_r[lps_pkg::POS_BITS-1] && !posy_r[lps_pkg::POS_BITS-1]
            && (posx_r < lim_x) && (posy_r < lim_y);
  end

  logic [7:0] col0, row0;
  logic [8:0] fx, fy;
  assign col0 = posx_r[15:8];
  assign row0 = posy_r[15:8];
  assign fx   = {1'b0, posx_r[7:0]};
  assign fy   = {1'b0, posy_r[7:0]};

  // store port
  lps_pkg::store_req_t st_req;
  logic [15:0]         st_rdata;

  lps_store u_store (
    .clk   (clk),
    .req   (st_req),
    .rdata (st_rdata)
  );

  // shared multiplier
  logic [23:0]                  mul_a;
  logic [8:0]                   mul_b;
  logic [lps_pkg::ACC_BITS-1:0] mul_p;
  assign mul_p = lps_pkg::ACC_BITS'(mul_a) * lps_pkg::ACC_BITS'(mul_b);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lps_pkg::ST_IDLE:
        if (in_xfer && in_kind && ({1'b0, in_sample_index} < count_r)) begin
          state_nxt = lps_pkg::ST_MUL;
        end
      lps_pkg::ST_MUL:  state_nxt = lps_pkg::ST_DIV;
      lps_pkg::ST_DIV:  if (div_stat.done) state_nxt = lps_pkg::ST_FIX;
      lps_pkg::ST_FIX:  state_nxt = axis_r ? lps_pkg::ST_CHK : lps_pkg::ST_MUL;
      lps_pkg::ST_CHK:  state_nxt = inside_c ? lps_pkg::ST_RD0 : lps_pkg::ST_DONE;
      lps_pkg::ST_RD0:  state_nxt = lps_pkg::ST_RD1;
      lps_pkg::ST_RD1:  state_nxt = lps_pkg::ST_RD2;
      lps_pkg::ST_RD2:  state_nxt = lps_pkg::ST_RD3;
      lps_pkg::ST_RD3:  state_nxt = lps_pkg::ST_RD4;
      lps_pkg::ST_RD4:  state_nxt = lps_pkg::ST_MAC0;
      lps_pkg::ST_MAC0: state_nxt = lps_pkg::ST_MAC1;
      lps_pkg::ST_MAC1: state_nxt = lps_pkg::ST_MAC2;
      lps_pkg::ST_MAC2: state_nxt = lps_pkg::ST_MAC3;
      lps_pkg::ST_MAC3: state_nxt = lps_pkg::ST_MAC4;
      lps_pkg::ST_MAC4: state_nxt = lps_pkg::ST_MAC5;
      lps_pkg::ST_MAC5: state_nxt = lps_pkg::ST_DONE;
      lps_pkg::ST_DONE: if (out_free) state_nxt = lps_pkg::ST_IDLE;
      default:          state_nxt = lps_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall     = (state_r != lps_pkg::ST_IDLE);
    div_start    = (state_r == lps_pkg::ST_MUL);
    st_req.we    = 1'b0;
    st_req.addr  = {row0, col0};
    st_req.wdata = in_pixel_value;
    mul_a        = '0;
    mul_b        = '0;
    unique case (state_r)
      lps_pkg::ST_IDLE: begin
        st_req.we   = in_xfer && !in_kind;
        st_req.addr = {in_pixel_row, in_pixel_col};
      end
      lps_pkg::ST_RD1:  st_req.addr = {row0, col0 + 8'd1};
      lps_pkg::ST_RD2:  st_req.addr = {row0 + 8'd1, col0};
      lps_pkg::ST_RD3:  st_req.addr = {row0 + 8'd1, col0 + 8'd1};
      lps_pkg::ST_MAC0: begin mul_a = 24'(pix_r[0]); mul_b = lps_pkg::ONE_FX - fx; end
      lps_pkg::ST_MAC1: begin mul_a = 24'(pix_r[1]); mul_b = fx; end
      lps_pkg::ST_MAC2: begin mul_a = 24'(pix_r[2]); mul_b = lps_pkg::ONE_FX - fx; end
      lps_pkg::ST_MAC3: begin mul_a = 24'(pix_r[3]); mul_b = fx; end
      lps_pkg::ST_MAC4: begin mul_a = top_r; mul_b = lps_pkg::ONE_FX - fy; end
      lps_pkg::ST_MAC5: begin mul_a = bot_r; mul_b = fy; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == lps_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      lps_pkg::ST_IDLE: begin
        idx_r  <= in_sample_index;
        axis_r <= 1'b0;
      end
      lps_pkg::ST_MUL:  neg_r <= d_s[18];
      lps_pkg::ST_FIX: begin
        if (axis_r) posy_r <= pos_s;
        else        posx_r <= pos_s;
        axis_r <= 1'b1;
      end
      lps_pkg::ST_CHK:  inside_r <= inside_c;
      lps_pkg::ST_RD1:  pix_r[0] <= st_rdata;
      lps_pkg::ST_RD2:  pix_r[1] <= st_rdata;
      lps_pkg::ST_RD3:  pix_r[2] <= st_rdata;
      lps_pkg::ST_RD4:  pix_r[3] <= st_rdata;
      lps_pkg::ST_MAC0: acc_r <= mul_p;
      lps_pkg::ST_MAC1: top_r <= 24'(acc_r + mul_p);
      lps_pkg::ST_MAC2: acc_r <= mul_p;
      lps_pkg::ST_MAC3: bot_r <= 24'(acc_r + mul_p);
      lps_pkg::ST_MAC4: acc_r <= mul_p;
      lps_pkg::ST_MAC5: acc_r <= acc_r + mul_p;
      lps_pkg::ST_DONE: begin
        if (out_free) begin
          out_num_r    <= idx_r;
          out_val_r    <= inside_r ? acc_r[lps_pkg::FRAC_BITS +: lps_pkg::VAL_BITS] : '0;
          out_inside_r <= inside_r;
          out_last_r   <= ({1'b0, idx_r} + 11'd1 == count_r);
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_sample_number = out_num_r;
  assign out_sample_value  = out_val_r;
  assign out_sample_inside = out_inside_r;
  assign out_last_sample   = out_last_r;

`ifndef SYNTHESIS
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == lps_pkg::ST_DONE))
    else $error("result loaded outside done state");
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_inside_r) |-> (out_val_r == '0))
    else $error("outside sample carries a value");
  a_blend_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lps_pkg::ST_MAC0) |-> inside_r)
    else $error("blend of an outside sample");
`endif

endmodule

// ===== dv/lps_profile_checker.sv =====
// Profile sampler checker: mirrors image and registers, predicts samples, compares results.
module lps_profile_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_pixel_col,
  input  logic [7:0]  in_pixel_row,
  input  logic [15:0] in_pixel_value,
  input  logic [9:0]  in_sample_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [9:0]  out_sample_number,
  input  logic [23:0] out_sample_value,
  input  logic        out_sample_inside,
  input  logic        out_last_sample,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data,
  output int          fail_count,
  output int          samples_owed
);

  typedef struct packed {
    logic [9:0]  number;
    logic [23:0] value;
    logic        in_area;
    logic        last;
  } sample_t;

  logic [15:0] pix_mirror [0:65535];
  logic [8:0]  img_w, img_h;
  logic signed [17:0] beg_x, beg_y, fin_x, fin_y;
  logic [10:0] n_samples;
  sample_t     owed_q[$];

  assign samples_owed = owed_q.size();

  function automatic longint offset_along(longint i, longint d, longint n);
    longint num, q;
    num = i * d;
    q = num / n;
    if ((num % n) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint pix(longint c, longint r);
    return longint'(pix_mirror[r * 256 + c]);
  endfunction

  function automatic sample_t interpolate_sample(logic [9:0] idx);
    sample_t s;
    longint w, h, px, py, cx, cy, fx, fy, top, bot;
    w = (img_w > lps_pkg::DIM_MAX) ? 256 : longint'(img_w);
    h = (img_h > lps_pkg::DIM_MAX) ? 256 : longint'(img_h);
    px = longint'(beg_x) + offset_along(idx, longint'(fin_x) - beg_x, n_samples) - 128;
    py = longint'(beg_y) + offset_along(idx, longint'(fin_y) - beg_y, n_samples) - 128;
    s.number  = idx;
    s.in_area = !(px < 0 || py < 0 || px >= (w - 1) * 256 || py >= (h - 1) * 256);
    s.value   = '0;
    if (s.in_area) begin
      cx = px / 256; cy = py / 256;
      fx = px % 256; fy = py % 256;
      top = pix(cx, cy) * (256 - fx) + pix(cx + 1, cy) * fx;
      bot = pix(cx, cy + 1) * (256 - fx) + pix(cx + 1, cy + 1) * fx;
      s.value = 24'((top * (256 - fy) + bot * fy) >> 8);
    end
    s.last = (32'(idx) + 1 == 32'(n_samples));
    return s;
  endfunction

  always @(posedge clk) begin
    sample_t e;
    if (!rst_n) begin
      img_w <= 9'd256; img_h <= 9'd256;
      beg_x <= '0; beg_y <= '0; fin_x <= '0; fin_y <= '0;
      n_samples <= '0;
      owed_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (lps_pkg::reg_idx_t'(cfg_index))
          lps_pkg::REG_WIDTH:   img_w <= cfg_data[8:0];
          lps_pkg::REG_HEIGHT:  img_h <= cfg_data[8:0];
          lps_pkg::REG_START_X: beg_x <= cfg_data;
          lps_pkg::REG_START_Y: beg_y <= cfg_data;
          lps_pkg::REG_END_X:   fin_x <= cfg_data;
          lps_pkg::REG_END_Y:   fin_y <= cfg_data;
          lps_pkg::REG_COUNT:   n_samples <= cfg_data[10:0];
          default: ;
        endcase
      end
      // Result side first so a same-edge input transfer queues behind.
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result: sample_number %0d", out_sample_number);
          fail_count++;
        end else begin
          e = owed_q.pop_front();
          if (out_sample_number !== e.number) begin
            $error("sample_number exp %0d act %0d", e.number, out_sample_number);
            fail_count++;
          end
          if (out_sample_value !== e.value) begin
            $error("sample_value exp %0h act %0h", e.value, out_sample_value);
            fail_count++;
          end
          if (out_sample_inside !== e.in_area) begin
            $error("sample_inside exp %0b act %0b", e.in_area, out_sample_inside);
            fail_count++;
          end
          if (out_last_sample !== e.last) begin
            $error("last_sample exp %0b act %0b", e.last, out_last_sample);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (!in_kind)
          pix_mirror[{in_pixel_row, in_pixel_col}] = in_pixel_value;
        else if (11'(in_sample_index) < n_samples)
          owed_q.push_back(interpolate_sample(in_sample_index));
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top: drives pixel loads, sample requests and register writes; gives the verdict.
module tb_top;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [7:0]  in_pixel_col = '0;
  logic [7:0]  in_pixel_row = '0;
  logic [15:0] in_pixel_value = '0;
  logic [9:0]  in_sample_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  out_sample_number;
  logic [23:0] out_sample_value;
  logic        out_sample_inside;
  logic        out_last_sample;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;

  int fail_count, samples_owed;
  bit quiet = 1'b0;      // no idling on either side
  bit hold_go = 1'b0;    // request a long result hold-off
  int stuck_cycles = 0;

  always #4 clk = ~clk;

  bilinear_line_profile_sampler i_dut (.*);

  lps_profile_checker i_chk (.*);

  // Watchdog: cycles with no transfer on any port.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles > 20000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold so the block backs up.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // One input transfer; valid stays high into the next item unless a gap is drawn.
  task automatic push_item(bit kind, logic [7:0] col, logic [7:0] row,
                           logic [15:0] val, logic [9:0] idx);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_pixel_col    <= col;
    in_pixel_row    <= row;
    in_pixel_value  <= val;
    in_sample_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (samples_owed != 0) @(posedge clk);
    // a dropped request or pixel load may still be in flight
    repeat (100) @(posedge clk);
  endtask

  // Reprogram every register, load the pixels the line can touch, then sample it.
  task automatic run_profile(int w, int h, int sx, int sy, int ex, int ey, int n,
                             int requests, bit long_hold);
    int wc, hc, lo_x, hi_x, lo_y, hi_y, idx;
    settle();
    cfg_we <= 1'b1;
    cfg_index <= lps_pkg::REG_WIDTH;   cfg_data <= 18'(w);  @(posedge clk);
    cfg_index <= lps_pkg::REG_HEIGHT;  cfg_data <= 18'(h);  @(posedge clk);
    cfg_index <= lps_pkg::REG_START_X; cfg_data <= 18'(sx); @(posedge clk);
    cfg_index <= lps_pkg::REG_START_Y; cfg_data <= 18'(sy); @(posedge clk);
    cfg_index <= lps_pkg::REG_END_X;   cfg_data <= 18'(ex); @(posedge clk);
    cfg_index <= lps_pkg::REG_END_Y;   cfg_data <= 18'(ey); @(posedge clk);
    cfg_index <= lps_pkg::REG_COUNT;   cfg_data <= 18'(n);  @(posedge clk);
    cfg_we <= 1'b0;
    // Interpolable pixels: span of the shifted line, clipped to the image.
    wc = (w > 256) ? 256 : w;
    hc = (h > 256) ? 256 : h;
    lo_x = (((sx < ex) ? sx : ex) - 128) >>> 8;
    hi_x = (((sx > ex) ? sx : ex) >>> 8) + 1;
    lo_y = (((sy < ey) ? sy : ey) - 128) >>> 8;
    hi_y = (((sy > ey) ? sy : ey) >>> 8) + 1;
    if (lo_x < 0) lo_x = 0;
    if (lo_y < 0) lo_y = 0;
    if (hi_x > wc - 1) hi_x = wc - 1;
    if (hi_y > hc - 1) hi_y = hc - 1;
    for (int r = lo_y; r <= hi_y; r++)
      for (int c = lo_x; c <= hi_x; c++)
        push_item(1'b0, 8'(c), 8'(r), pick_pixel(), 10'($urandom));
    if (long_hold) hold_go = 1'b1;
    if (n > 0) begin
      push_item(1'b1, 8'($urandom), 8'($urandom), 16'($urandom), 10'(n - 1));
      push_item(1'b1, 8'($urandom), 8'($urandom), 16'($urandom), 10'd0);
    end
    for (int k = 0; k < requests; k++) begin
      if ($urandom_range(0, 5) == 0) begin
        // stray pixel load, may land outside the configured image
        push_item(1'b0, 8'($urandom), 8'($urandom), pick_pixel(), 10'($urandom));
      end else begin
        idx = (n > 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, n - 1)
                                                   : $urandom_range(0, 1023);
        push_item(1'b1, 8'($urandom), 8'($urandom), 16'($urandom), 10'(idx));
      end
    end
  endtask

  initial begin
    int w, h, sx, sy, d, n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: count is zero, so requests are dropped.
    push_item(1'b0, 8'd0, 8'd0, 16'h0000, 10'd0);
    push_item(1'b0, 8'd255, 8'd255, 16'hFFFF, 10'h3FF);
    push_item(1'b1, 8'hFF, 8'hFF, 16'hFFFF, 10'd0);
    push_item(1'b1, 8'd0, 8'd0, 16'd0, 10'd1023);

    // Full-range diagonals across a tiny image, maximum count.
    run_profile(4, 4, -131072, -131072, 131071, 131071, 1024, 10, 1'b0);
    run_profile(3, 5, 131071, -131072, -131072, 131071, 1024, 8, 1'b0);
    // Oversized width saturates; zero height puts every sample outside the image.
    run_profile(511, 0, 256, 256, 2000, 900, 7, 6, 1'b0);
    // Smallest interpolable image, exact pixel centers and edges.
    run_profile(2, 2, 128, 128, 384, 384, 4, 6, 1'b0);
    // Count of zero with a valid line: nothing comes back.
    run_profile(256, 256, 65280, 65280, 65535, 65535, 0, 4, 1'b0);

    for (int p = 0; p < 14; p++) begin
      if (p >= 12) quiet = 1'b1;
      case ($urandom_range(0, 5))
        0: w = $urandom_range(1, 4);
        1: w = $urandom_range(5, 40);
        2, 3: w = $urandom_range(41, 256);
        4: w = $urandom_range(257, 511);
        default: w = $urandom_range(0, 2);
      endcase
      h = (p % 3 == 0) ? w : $urandom_range(1, 256);
      if (w > 256) begin
        h = $urandom_range(1, 511);
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 1024) : $urandom_range(1, 64);
      if (p == 5) n = 0;
      sx = $urandom_range(0, 256 * 256 + 512) - 256;
      sy = $urandom_range(0, 256 * 256 + 512) - 256;
      if (w <= 256) sx = $urandom_range(0, w * 256 + 512) - 256;
      if (h <= 256) sy = $urandom_range(0, h * 256 + 512) - 256;
      d = $urandom_range(0, 3000) - 1500;
      run_profile(w, h, sx, sy, sx + d, sy + $urandom_range(0, 3000) - 1500, n, 30,
                  p == 2);
    end

    settle();
    if (fail_count == 0 && samples_owed == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
